// ===== hw/rtl/smomp_pkg.sv =====
// Shared types and constants for the square-root-of-minus-one block.
package smomp_pkg;

  localparam int PRIME_BITS_DEF   = 40;
  localparam int SEARCH_LIMIT_DEF = 1023;

  localparam int IN_W        = 40;
  localparam int IN_TDATA_W  = 40;
  localparam int STATUS_W    = 2;
  localparam int NONRES_W    = 10;
  localparam int ROOT_W      = 40;
  localparam int OUT_TDATA_W = 96;
  localparam int QUEUE_DEPTH = 2;
  localparam int MIN_PRIME   = 5;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_MOD = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_NR   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JAC,
    S_POW,
    S_MUL
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hw/rtl/smomp_front.sv =====
// Front end: takes input transactions, masks the modulus and flags a bad modulus.
module smomp_front
  import smomp_pkg::*;
#(
  parameter int PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  qstat_t                q_stat,
  output logic                  push,
  output logic [PRIME_BITS:0]   push_data
);

  logic [PRIME_BITS-1:0] p;
  logic                  bad;

  assign p         = PRIME_BITS'(in_tdata[IN_W-1:0]);
  assign bad       = (p < PRIME_BITS'(MIN_PRIME)) || (p[1:0] != 2'b01);
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;
  assign push_data = {bad, p};

endmodule

// ===== hw/rtl/smomp_queue.sv =====
// Short queue between the front end and the arithmetic back end.
module smomp_queue
  import smomp_pkg::*;
#(
  parameter int W = 41
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output qstat_t       q_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNTW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// ===== hw/rtl/smomp_back.sv =====
// Back end: Jacobi search for the non-residue, modular exponentiation, result register.
module smomp_back
  import smomp_pkg::*;
#(
  parameter int PRIME_BITS   = PRIME_BITS_DEF,
  parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [PRIME_BITS:0]    head,
  input  qstat_t                 q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [NONRES_W-1:0]    out_nonres,
  output logic [ROOT_W-1:0]      out_root,
  output logic [ROOT_W-1:0]      out_other
);

  localparam int AW = $clog2(SEARCH_LIMIT + 1);
  localparam int XW = (PRIME_BITS > AW) ? PRIME_BITS : AW;
  localparam int CW = $clog2(PRIME_BITS);
  localparam int PB = PRIME_BITS;

  back_state_t       st_r, st_nxt;
  logic [AW-1:0]     a_r;
  logic [XW-1:0]     x_r, n_r;
  logic              neg_r;
  logic [PB-1:0]     p_r, acc_r, mx_r, my_r, macc_r;
  logic [CW-1:0]     cnt_r, eidx_r;
  logic              sq_r;
  logic              out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [NONRES_W-1:0] nonres_r;
  logic [ROOT_W-1:0]   root_r, other_r;

  // Jacobi step.
  logic x_zero, found, a_last, flip2, x_lt_n, flip_q;
  assign x_zero = (x_r == '0);
  assign found  = (n_r == XW'(1)) && neg_r;
  assign a_last = (a_r == AW'(SEARCH_LIMIT));
  assign flip2  = (n_r[2:0] == 3'd3) || (n_r[2:0] == 3'd5);
  assign x_lt_n = (x_r < n_r);
  assign flip_q = (x_r[1:0] == 2'b11) && (n_r[1:0] == 2'b11);

  // One bit of the shift-and-add modular multiplier.
  logic [PB:0]   pe, dbl, dbl_m, sum, mres;
  logic [PB-1:0] mres_pb;
  assign pe      = {1'b0, p_r};
  assign dbl     = {macc_r, 1'b0};
  assign dbl_m   = (dbl >= pe) ? dbl - pe : dbl;
  assign sum     = dbl_m + (my_r[cnt_r] ? {1'b0, mx_r} : '0);
  assign mres    = (sum >= pe) ? sum - pe : sum;
  assign mres_pb = mres[PB-1:0];

  logic mul_last, need_mul, pow_last;
  assign mul_last = (cnt_r == '0);
  assign need_mul = sq_r && p_r[eidx_r];
  assign pow_last = (eidx_r == CW'(2));

  // Outputs of the controller.
  always_comb begin
    pop = (st_r == S_IDLE) && !q_stat.empty && !out_valid_r;
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (pop && !head[PB]) st_nxt = S_JAC;
      end
      S_JAC: begin
        if (x_zero) begin
          if (found) st_nxt = S_POW;
          else if (a_last) st_nxt = S_IDLE;
        end
      end
      S_POW: st_nxt = S_MUL;
      S_MUL: begin
        if (mul_last && !need_mul) st_nxt = pow_last ? S_IDLE : S_POW;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && head[PB]) begin
        out_valid_r <= 1'b1;
      end
      if (st_r == S_JAC && x_zero && !found && a_last) begin
        out_valid_r <= 1'b1;
      end
      if (st_r == S_MUL && mul_last && !need_mul && pow_last) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        if (pop) begin
          p_r   <= head[PB-1:0];
          a_r   <= AW'(2);
          x_r   <= XW'(2);
          n_r   <= XW'(head[PB-1:0]);
          neg_r <= 1'b0;
          if (head[PB]) begin
            status_r <= STAT_BAD_MOD;
            nonres_r <= '0;
            root_r   <= '0;
            other_r  <= '0;
          end
        end
      end
      S_JAC: begin
        if (x_zero) begin
          if (found) begin
            acc_r  <= PB'(1);
            eidx_r <= CW'(PB - 1);
          end else if (a_last) begin
            status_r <= STAT_NO_NR;
            nonres_r <= '0;
            root_r   <= '0;
            other_r  <= '0;
          end else begin
            a_r   <= a_r + 1'b1;
            x_r   <= XW'(a_r + 1'b1);
            n_r   <= XW'(p_r);
            neg_r <= 1'b0;
          end
        end else if (!x_r[0]) begin
          x_r   <= x_r >> 1;
          neg_r <= neg_r ^ flip2;
        end else if (x_lt_n) begin
          // Reciprocity swap folded with the following subtraction.
          x_r   <= n_r - x_r;
          n_r   <= x_r;
          neg_r <= neg_r ^ flip_q;
        end else begin
          x_r <= x_r - n_r;
        end
      end
      S_POW: begin
        mx_r   <= acc_r;
        my_r   <= acc_r;
        macc_r <= '0;
        cnt_r  <= CW'(PB - 1);
        sq_r   <= 1'b1;
      end
      S_MUL: begin
        if (!mul_last) begin
          macc_r <= mres_pb;
          cnt_r  <= cnt_r - 1'b1;
        end else begin
          acc_r <= mres_pb;
          if (need_mul) begin
            mx_r   <= mres_pb;
            my_r   <= PB'(a_r);
            macc_r <= '0;
            cnt_r  <= CW'(PB - 1);
            sq_r   <= 1'b0;
          end else if (pow_last) begin
            status_r <= STAT_OK;
            nonres_r <= NONRES_W'(a_r);
            root_r   <= ROOT_W'(mres_pb);
            other_r  <= ROOT_W'(p_r - mres_pb);
          end else begin
            eidx_r <= eidx_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_nonres = nonres_r;
  assign out_root   = root_r;
  assign out_other  = other_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != STAT_OK) |-> (nonres_r == '0) && (root_r == '0))
    else $error("failed item carries nonzero payload");

  a_n_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_JAC) |-> n_r[0])
    else $error("Jacobi denominator became even");

  a_macc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |-> (macc_r < p_r))
    else $error("multiplier accumulator not reduced");

  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !out_valid_r)
    else $error("job started while result register busy");

endmodule

// ===== hw/rtl/sqrt_minus_one_mod_prime.sv =====
// Top level of the square-root-of-minus-one-modulo-a-prime block.
// For each modulus p (an odd prime with p = 1 mod 4) the block finds the
// least base a >= 2 whose Jacobi symbol (a/p) is -1, raises it to (p-1)/4
// modulo p and returns a, the root s and p - s, the two square roots of -1.
// A modulus below 5 or not 1 mod 4 gives status 1, and a search that passes
// SEARCH_LIMIT gives status 2; both return zero payload. Only the low
// PRIME_BITS bits of the input are used. A front end classifies each
// transaction and places it in a two-entry queue, so the input keeps taking
// transactions while the queue has room, as the back end works and a result
// waits in its output register. The back end handles one item at a time.
// For a valid modulus the Jacobi search runs one shift or subtraction per
// cycle, and the exponentiation runs PRIME_BITS-2 squarings plus one
// multiplication for each set bit of (p-1)/4 on a bit-serial modular
// multiplier.
module sqrt_minus_one_mod_prime
  import smomp_pkg::*;
#(
  parameter int PRIME_BITS   = PRIME_BITS_DEF,
  parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [39:0] prime
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] nonresidue, [49:10] root,
                                             // [89:50] other_root, rest zero
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  qstat_t              q_stat;
  logic                push, pop;
  logic [PRIME_BITS:0] push_data, head;
  logic [NONRES_W-1:0] nonres;
  logic [ROOT_W-1:0]   root, other;

  smomp_front #(.PRIME_BITS(PRIME_BITS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  smomp_queue #(.W(PRIME_BITS + 1)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  smomp_back #(.PRIME_BITS(PRIME_BITS), .SEARCH_LIMIT(SEARCH_LIMIT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_nonres (nonres),
    .out_root   (root),
    .out_other  (other)
  );

  // Results are packed lowest field first and padded to whole bytes.
  assign out_tdata = {6'b0, other, root, nonres};

endmodule
